// File: hdl/adctf_pkg.sv
// ----------------------------------------------------------------------------
// adctf_pkg: shared definitions for the ADC temperature filter
// Field widths, register reset values, parameter defaults and register codes.
// ----------------------------------------------------------------------------
package adctf_pkg;

  // payload field widths
  localparam int ADC_W    = 12;
  localparam int MS_W     = 16;
  localparam int FILT_W   = 13;

  // configuration register widths
  localparam int LIMIT_W  = 12;
  localparam int DELAY_W  = 16;
  localparam int GAIN_W   = 10;
  localparam int OFFSET_W = 20;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // temperature conversion: (gain*mean - offset) / 2**TEMP_FRAC_W
  localparam int TEMP_FRAC_W = 11;
  localparam int TEMP_W      = 12;

  // register reset values
  localparam logic [LIMIT_W-1:0]  LOW_LIMIT_RST   = LIMIT_W'(50);
  localparam logic [LIMIT_W-1:0]  HIGH_LIMIT_RST  = LIMIT_W'(2000);
  localparam logic [DELAY_W-1:0]  FAULT_DELAY_RST = DELAY_W'(1000);
  localparam logic [GAIN_W-1:0]   CONV_GAIN_RST   = GAIN_W'(165);
  localparam logic [OFFSET_W-1:0] CONV_OFFSET_RST = OFFSET_W'(102380);

  // filter length defaults
  localparam int SAMPLES_PER_READING_DEF  = 20;
  localparam int READINGS_PER_AVERAGE_DEF = 20;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_LIMIT   = 3'd0,
    CFG_HIGH_LIMIT  = 3'd1,
    CFG_FAULT_DELAY = 3'd2,
    CFG_CONV_GAIN   = 3'd3,
    CFG_CONV_OFFSET = 3'd4
  } cfg_reg_e;

endpackage

// File: hdl/adctf_sample_if.sv
// ----------------------------------------------------------------------------
// adctf_sample_if: raw sample request channel
// Carries one ADC conversion result and the millisecond tick it was taken at.
// ----------------------------------------------------------------------------
interface adctf_sample_if;
  logic                          valid;
  logic                          ready;
  logic [adctf_pkg::ADC_W-1:0]   sample;
  logic [adctf_pkg::MS_W-1:0]    now_ms;

  modport source (output valid, output sample, output now_ms, input ready);
  modport sink   (input valid, input sample, input now_ms, output ready);
endinterface

// File: hdl/adctf_result_if.sv
// ----------------------------------------------------------------------------
// adctf_result_if: filtered reading request channel
// Carries one filtered temperature with the mean and the fault flags.
// ----------------------------------------------------------------------------
interface adctf_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [adctf_pkg::FILT_W-1:0] filtered_half_deg;
  logic [adctf_pkg::ADC_W-1:0]         mean_sample;
  logic                                fault;
  logic                                source_high;
  logic                                source_low;

  modport source (
    output valid, output filtered_half_deg, output mean_sample,
    output fault, output source_high, output source_low, input ready
  );
  modport sink (
    input valid, input filtered_half_deg, input mean_sample,
    input fault, input source_high, input source_low, output ready
  );
endinterface

// File: hdl/adctf_cfg_if.sv
// ----------------------------------------------------------------------------
// adctf_cfg_if: configuration write channel
// Carries a register index and the data to write into it.
// ----------------------------------------------------------------------------
interface adctf_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [adctf_pkg::CFG_IDX_W-1:0]     index;
  logic [adctf_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/adc_temperature_filter_fault_monitor.sv
// ----------------------------------------------------------------------------
// adc_temperature_filter_fault_monitor: ADC temperature filter and fault monitor
// The block takes one raw sample request per clock cycle. Samples are summed
// at the input; the sample that completes a reading (every SAMPLES_PER_READING
// samples) enters a seven-register pipeline: mean by reciprocal multiply,
// gain multiply and range check, offset and truncating divide by 2048, block
// sum, block-average reciprocal multiply, then the result register. A result
// request appears once the completing sample has passed through every one of
// these registers. The sustained rate is one sample per cycle, set by the add
// into the sample accumulator; intermediate stages close up bubbles,
// so the input only stalls when a completing sample finds the whole pipeline
// full and the result side not taking. Samples that do not complete a reading
// are taken even then. Configuration writes are taken in every cycle and must
// only be issued while no reading is in flight. Output is temperature plus
// block average in half degrees, forced to zero while a fault is reported.
// ----------------------------------------------------------------------------
module adc_temperature_filter_fault_monitor #(
  parameter int SAMPLES_PER_READING  = adctf_pkg::SAMPLES_PER_READING_DEF,
  parameter int READINGS_PER_AVERAGE = adctf_pkg::READINGS_PER_AVERAGE_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  adctf_sample_if.sink   samp_i,
  adctf_cfg_if.sink      cfg_i,
  adctf_result_if.source res_o
);

  // --------------------------------------------------------------------------
  // derived sizes
  // --------------------------------------------------------------------------
  // sample sum and exact reciprocal of the sample count
  localparam int SCntW   = (SAMPLES_PER_READING > 1) ? $clog2(SAMPLES_PER_READING) : 1;
  localparam int SumW    = adctf_pkg::ADC_W + $clog2(SAMPLES_PER_READING);
  localparam int ShiftN  = SumW + $clog2(SAMPLES_PER_READING);
  localparam int RecipNW = ShiftN + 1;
  localparam longint RecipNVal =
    ((longint'(1) << ShiftN) + SAMPLES_PER_READING - 1) / SAMPLES_PER_READING;
  localparam logic [RecipNW-1:0] RecipN = RecipNW'(RecipNVal);
  localparam logic [SCntW-1:0] SCntLast = SCntW'(SAMPLES_PER_READING - 1);

  // reading sum and exact reciprocal of the reading count
  localparam int RCntW   = (READINGS_PER_AVERAGE > 1) ? $clog2(READINGS_PER_AVERAGE) : 1;
  localparam int RAccW   = adctf_pkg::TEMP_W + $clog2(READINGS_PER_AVERAGE);
  localparam int ShiftM  = RAccW + $clog2(READINGS_PER_AVERAGE);
  localparam int RecipMW = ShiftM + 1;
  localparam longint RecipMVal =
    ((longint'(1) << ShiftM) + READINGS_PER_AVERAGE - 1) / READINGS_PER_AVERAGE;
  localparam logic [RecipMW-1:0] RecipM = RecipMW'(RecipMVal);
  localparam logic [RCntW-1:0] RCntLast = RCntW'(READINGS_PER_AVERAGE - 1);

  // conversion datapath
  localparam int ProdW = adctf_pkg::GAIN_W + adctf_pkg::ADC_W;
  localparam int DiffW = ProdW + 1;
  localparam logic [DiffW-1:0] TruncBias = DiffW'((1 << adctf_pkg::TEMP_FRAC_W) - 1);

  localparam int AdcW  = adctf_pkg::ADC_W;
  localparam int MsW   = adctf_pkg::MS_W;
  localparam int TempW = adctf_pkg::TEMP_W;
  localparam int FiltW = adctf_pkg::FILT_W;

  // per-reading status carried down the pipe with the reading
  typedef struct packed {
    logic [AdcW-1:0] mean;
    logic            fault;
    logic            src_high;
    logic            src_low;
  } stat_t;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [adctf_pkg::LIMIT_W-1:0]  low_limit_q, high_limit_q;
  logic [adctf_pkg::DELAY_W-1:0]  fault_delay_q;
  logic [adctf_pkg::GAIN_W-1:0]   conv_gain_q;
  logic [adctf_pkg::OFFSET_W-1:0] conv_offset_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_limit_q   <= adctf_pkg::LOW_LIMIT_RST;
      high_limit_q  <= adctf_pkg::HIGH_LIMIT_RST;
      fault_delay_q <= adctf_pkg::FAULT_DELAY_RST;
      conv_gain_q   <= adctf_pkg::CONV_GAIN_RST;
      conv_offset_q <= adctf_pkg::CONV_OFFSET_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        adctf_pkg::CFG_LOW_LIMIT:   low_limit_q   <= cfg_i.data[adctf_pkg::LIMIT_W-1:0];
        adctf_pkg::CFG_HIGH_LIMIT:  high_limit_q  <= cfg_i.data[adctf_pkg::LIMIT_W-1:0];
        adctf_pkg::CFG_FAULT_DELAY: fault_delay_q <= cfg_i.data[adctf_pkg::DELAY_W-1:0];
        adctf_pkg::CFG_CONV_GAIN:   conv_gain_q   <= cfg_i.data[adctf_pkg::GAIN_W-1:0];
        adctf_pkg::CFG_CONV_OFFSET: conv_offset_q <= cfg_i.data[adctf_pkg::OFFSET_W-1:0];
        default: ;  // unknown index: write dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // pipeline valids and ready chain (each stage fills when empty or moving)
  // --------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, ov_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy_out;

  assign rdy_out = !ov_q || res_o.ready;
  assign rdy6    = !v6_q || rdy_out;
  assign rdy5    = !v5_q || rdy6;
  assign rdy4    = !v4_q || rdy5;
  assign rdy3    = !v3_q || rdy4;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;

  // moves out of the stages that carry state of their own
  logic mv2, mv4, mv6;
  assign mv2 = v2_q && rdy3;
  assign mv4 = v4_q && rdy5;
  assign mv6 = v6_q && rdy_out;

  // --------------------------------------------------------------------------
  // input: sample accumulation
  // --------------------------------------------------------------------------
  logic [SumW-1:0]  sample_acc_q;
  logic [SCntW-1:0] sample_cnt_q;
  logic [SumW-1:0]  sum_d;
  logic             acc_done, in_acc, load1;

  assign acc_done     = (sample_cnt_q == SCntLast);
  // only the sample that closes a reading needs room in the pipe
  assign samp_i.ready = !acc_done || rdy1;
  assign in_acc       = samp_i.valid && samp_i.ready;
  assign load1        = in_acc && acc_done;
  assign sum_d        = sample_acc_q + SumW'(samp_i.sample);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_acc_q <= '0;
      sample_cnt_q <= '0;
    end else if (in_acc) begin
      if (acc_done) begin
        sample_acc_q <= '0;
        sample_cnt_q <= '0;
      end else begin
        sample_acc_q <= sum_d;
        sample_cnt_q <= sample_cnt_q + SCntW'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 2 input: mean = sum / N by exact reciprocal multiply
  // --------------------------------------------------------------------------
  logic [SumW-1:0]         sum1_q;
  logic [MsW-1:0]          now1_q;
  logic [SumW+RecipNW-1:0] mean_prod;
  logic [AdcW-1:0]         mean_d;

  assign mean_prod = (SumW+RecipNW)'(sum1_q) * (SumW+RecipNW)'(RecipN);
  assign mean_d    = mean_prod[ShiftN +: AdcW];

  // --------------------------------------------------------------------------
  // stage 3 input: gain multiply and range / persistence check
  // --------------------------------------------------------------------------
  logic [AdcW-1:0]  mean2_q;
  logic [MsW-1:0]   now2_q;
  logic [MsW-1:0]   last_ok_q, last_ok_d;
  logic             hi_latch_q, hi_latch_d;
  logic             lo_latch_q, lo_latch_d;
  logic             is_low, is_high, late, fault_d;
  logic [MsW-1:0]   elapsed;
  logic [ProdW-1:0] gain_prod;
  stat_t            stat3_d;

  assign gain_prod = ProdW'(conv_gain_q) * ProdW'(mean2_q);
  assign is_low    = (mean2_q <= low_limit_q);
  assign is_high   = (mean2_q >= high_limit_q);
  assign elapsed   = now2_q - last_ok_q;   // wraps with the tick
  assign late      = (elapsed > fault_delay_q);

  always_comb begin
    last_ok_d  = last_ok_q;
    hi_latch_d = hi_latch_q;
    lo_latch_d = lo_latch_q;
    fault_d    = 1'b0;
    if (is_low || is_high) begin
      if (late) begin
        fault_d = 1'b1;
        // a high latch already set keeps the fault on the high side
        if (is_low && !hi_latch_q) begin
          lo_latch_d = 1'b1;
          hi_latch_d = 1'b0;
        end else begin
          lo_latch_d = 1'b0;
          hi_latch_d = 1'b1;
        end
      end
    end else begin
      last_ok_d  = now2_q;
      hi_latch_d = 1'b0;
      lo_latch_d = 1'b0;
    end
  end

  assign stat3_d = '{mean: mean2_q, fault: fault_d, src_high: hi_latch_d, src_low: lo_latch_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_ok_q  <= '0;
      hi_latch_q <= 1'b0;
      lo_latch_q <= 1'b0;
    end else if (mv2) begin
      last_ok_q  <= last_ok_d;
      hi_latch_q <= hi_latch_d;
      lo_latch_q <= lo_latch_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 4 input: subtract offset, divide by 2048 toward zero
  // --------------------------------------------------------------------------
  logic [ProdW-1:0]        prod3_q;
  stat_t                   stat3_q;
  logic signed [DiffW-1:0] diff, diff_adj;
  logic signed [TempW-1:0] temp_d;

  assign diff     = $signed({1'b0, prod3_q})
                  - $signed({{(DiffW-adctf_pkg::OFFSET_W){1'b0}}, conv_offset_q});
  // negative values get the divisor minus one added so the shift truncates
  assign diff_adj = diff + $signed(diff[DiffW-1] ? TruncBias : '0);
  assign temp_d   = diff_adj[adctf_pkg::TEMP_FRAC_W +: TempW];

  // --------------------------------------------------------------------------
  // stage 5 input: block sum of readings
  // --------------------------------------------------------------------------
  logic signed [TempW-1:0] temp4_q;
  stat_t                   stat4_q;
  logic signed [RAccW-1:0] reading_acc_q, total;
  logic [RCntW-1:0]        reading_cnt_q;
  logic                    rdone;
  logic [RAccW-1:0]        mag_d;

  assign total = reading_acc_q + RAccW'(temp4_q);
  assign rdone = (reading_cnt_q == RCntLast);
  assign mag_d = total[RAccW-1] ? RAccW'(-total) : RAccW'(total);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reading_acc_q <= '0;
      reading_cnt_q <= '0;
    end else if (mv4) begin
      if (rdone) begin
        reading_acc_q <= '0;
        reading_cnt_q <= '0;
      end else begin
        reading_acc_q <= total;
        reading_cnt_q <= reading_cnt_q + RCntW'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 6 input: block magnitude / M by exact reciprocal multiply
  // --------------------------------------------------------------------------
  logic signed [TempW-1:0]    temp5_q;
  stat_t                      stat5_q;
  logic                       blk5_q, neg5_q;
  logic [RAccW-1:0]           mag5_q;
  logic [RAccW+RecipMW-1:0]   avg_prod;
  logic [TempW-1:0]           qmag_d;

  assign avg_prod = (RAccW+RecipMW)'(mag5_q) * (RAccW+RecipMW)'(RecipM);
  assign qmag_d   = avg_prod[ShiftM +: TempW];

  // --------------------------------------------------------------------------
  // result input: block average update and filtered value
  // --------------------------------------------------------------------------
  logic signed [TempW-1:0] temp6_q;
  stat_t                   stat6_q;
  logic                    blk6_q, neg6_q;
  logic [TempW-1:0]        qmag6_q;
  logic signed [TempW-1:0] block_avg_q, bavg_d;
  logic signed [FiltW-1:0] filt_d;

  always_comb begin
    bavg_d = block_avg_q;
    if (blk6_q) begin
      bavg_d = neg6_q ? -$signed(qmag6_q) : $signed(qmag6_q);
    end
  end

  // a reading that closes a block already sees the new average
  assign filt_d = stat6_q.fault ? '0 : (FiltW'(temp6_q) + FiltW'(bavg_d));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_avg_q <= '0;
    end else if (mv6) begin
      block_avg_q <= bavg_d;
    end
  end

  // --------------------------------------------------------------------------
  // pipeline valid bits
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (rdy1)    v1_q <= load1;
      if (rdy2)    v2_q <= v1_q;
      if (rdy3)    v3_q <= v2_q;
      if (rdy4)    v4_q <= v3_q;
      if (rdy5)    v5_q <= v4_q;
      if (rdy6)    v6_q <= v5_q;
      if (rdy_out) ov_q <= v6_q;
    end
  end

  // --------------------------------------------------------------------------
  // pipeline payload (no reset)
  // --------------------------------------------------------------------------
  logic signed [FiltW-1:0] out_filt_q;
  stat_t                   out_stat_q;

  always_ff @(posedge clk_i) begin
    if (load1) begin
      sum1_q <= sum_d;
      now1_q <= samp_i.now_ms;
    end
    if (v1_q && rdy2) begin
      mean2_q <= mean_d;
      now2_q  <= now1_q;
    end
    if (mv2) begin
      prod3_q <= gain_prod;
      stat3_q <= stat3_d;
    end
    if (v3_q && rdy4) begin
      temp4_q <= temp_d;
      stat4_q <= stat3_q;
    end
    if (mv4) begin
      temp5_q <= temp4_q;
      stat5_q <= stat4_q;
      blk5_q  <= rdone;
      neg5_q  <= total[RAccW-1];
      mag5_q  <= mag_d;
    end
    if (v5_q && rdy6) begin
      temp6_q <= temp5_q;
      stat6_q <= stat5_q;
      blk6_q  <= blk5_q;
      neg6_q  <= neg5_q;
      qmag6_q <= qmag_d;
    end
    if (mv6) begin
      out_filt_q <= filt_d;
      out_stat_q <= stat6_q;
    end
  end

  assign res_o.valid             = ov_q;
  assign res_o.filtered_half_deg = out_filt_q;
  assign res_o.mean_sample       = out_stat_q.mean;
  assign res_o.fault             = out_stat_q.fault;
  assign res_o.source_high       = out_stat_q.src_high;
  assign res_o.source_low        = out_stat_q.src_low;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // input stalls only behind a full, blocked first stage
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !samp_i.ready |-> (acc_done && v1_q && !rdy2))
    else $error("sample input stalled without a blocked first stage");

  // the sample that closes a reading always lands in the first stage
  a_reading_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && acc_done) |=> v1_q)
    else $error("completed reading lost at first stage");

  // the two source flags are exclusive
  a_latch_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(hi_latch_q && lo_latch_q))
    else $error("high and low source flags both set");

  // block average only changes when a block-closing reading leaves
  a_bavg_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(block_avg_q) |-> $past(mv6 && blk6_q))
    else $error("block average changed outside a block end");

  // a faulted result carries a zero temperature
  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.fault) |-> (res_o.filtered_half_deg == '0))
    else $error("faulted result with nonzero temperature");

endmodule

// File: tb/tb_adc_temperature_filter_fault_monitor.sv
// ----------------------------------------------------------------------------
// tb_adc_temperature_filter_fault_monitor: self-checking bench for the ADC filter
// Streams timestamped ADC samples through the block under several register
// settings, with random idle cycles on both sides and one long result
// back-pressure stretch. A predictor computes every reading and
// its fault flags, and each result request is compared field by field.
// ----------------------------------------------------------------------------
module tb_adc_temperature_filter_fault_monitor;

  localparam int ADC_W       = adctf_pkg::ADC_W;
  localparam int MS_W        = adctf_pkg::MS_W;
  localparam int FILT_W      = adctf_pkg::FILT_W;
  localparam int LIMIT_W     = adctf_pkg::LIMIT_W;
  localparam int DELAY_W     = adctf_pkg::DELAY_W;
  localparam int GAIN_W      = adctf_pkg::GAIN_W;
  localparam int OFFSET_W    = adctf_pkg::OFFSET_W;
  localparam int CFG_IDX_W   = adctf_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W  = adctf_pkg::CFG_DATA_W;
  localparam int TEMP_FRAC_W = adctf_pkg::TEMP_FRAC_W;

  localparam int SPR                = adctf_pkg::SAMPLES_PER_READING_DEF;
  localparam int RPA                = adctf_pkg::READINGS_PER_AVERAGE_DEF;
  localparam int ADC_MAX            = (1 << ADC_W) - 1;
  localparam int MAX_GAP            = 14;
  localparam int HOLD_CYCLES        = 600;
  localparam int DRAIN_CYCLES       = 16;
  localparam int CYCLE_LIMIT        = 200000;
  localparam int PHASES             = 8;
  localparam int PRESSURE_PHASE     = 4;
  localparam int READINGS_PER_PHASE = 7;
  localparam int PRESSURE_READINGS  = 20;

  typedef enum int {IDLE_NONE, IDLE_SOME, IDLE_HEAVY} idle_mode_e;
  typedef enum int {LVL_OK, LVL_LOW, LVL_HIGH, LVL_BORDER, LVL_WIDE} level_e;

  // one sample request plus the idle cycles the sender takes after it
  typedef struct {
    logic [ADC_W-1:0] sample;
    logic [MS_W-1:0]  now_ms;
    int unsigned      gap;
  } adc_req_t;

  typedef struct {
    logic signed [FILT_W-1:0] filtered;
    logic [ADC_W-1:0]         mean;
    logic                     fault;
    logic                     src_high;
    logic                     src_low;
  } reading_t;

  // clock, reset and the bench-side copies of every block input
  logic                  clk_i   = 1'b0;
  logic                  rst_ni  = 1'b0;
  logic                  s_valid = 1'b0;
  logic [ADC_W-1:0]      s_sample = '0;
  logic [MS_W-1:0]       s_now   = '0;
  logic                  r_ready = 1'b0;
  logic                  c_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  c_index = '0;
  logic [CFG_DATA_W-1:0] c_data  = '0;

  adctf_sample_if samp_if ();
  adctf_result_if res_if ();
  adctf_cfg_if    cfg_if ();

  assign samp_if.valid  = s_valid;
  assign samp_if.sample = s_sample;
  assign samp_if.now_ms = s_now;
  assign res_if.ready   = r_ready;
  assign cfg_if.valid   = c_valid;
  assign cfg_if.index   = c_index;
  assign cfg_if.data    = c_data;

  adc_temperature_filter_fault_monitor #(
    .SAMPLES_PER_READING  (SPR),
    .READINGS_PER_AVERAGE (RPA)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .samp_i (samp_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // register shadow, follows every accepted write
  logic [LIMIT_W-1:0]  low_lim_q  = adctf_pkg::LOW_LIMIT_RST;
  logic [LIMIT_W-1:0]  high_lim_q = adctf_pkg::HIGH_LIMIT_RST;
  logic [DELAY_W-1:0]  delay_q    = adctf_pkg::FAULT_DELAY_RST;
  logic [GAIN_W-1:0]   gain_q     = adctf_pkg::CONV_GAIN_RST;
  logic [OFFSET_W-1:0] offset_q   = adctf_pkg::CONV_OFFSET_RST;

  // filter and fault state as the block should hold it
  int                  sample_sum = 0;
  int                  sample_n   = 0;
  int                  temp_sum   = 0;
  int                  temp_n     = 0;
  int                  blk_avg    = 0;
  logic [MS_W-1:0]     ok_stamp   = '0;
  bit                  hi_latch   = 1'b0;
  bit                  lo_latch   = 1'b0;

  adc_req_t            pending_reqs[$];
  reading_t            expected_readings[$];

  // handshake bookkeeping
  int unsigned         src_gap   = 0;
  int unsigned         snk_gap   = 0;
  int unsigned         hold_left = 0;
  bit                  hold_req  = 1'b0;
  idle_mode_e          src_mode  = IDLE_NONE;
  idle_mode_e          snk_mode  = IDLE_NONE;
  int                  err_cnt   = 0;
  int unsigned         cycle_cnt = 0;
  adc_req_t            sent_req;

  // stimulus timeline: running tick and the last tick of an in-range reading
  logic [MS_W-1:0]     tick     = '0;
  logic [MS_W-1:0]     ok_guess = '0;

  function automatic int unsigned draw_gap(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: return 0;
      IDLE_SOME: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_GAP) : 0;
      default:   return $urandom_range(0, MAX_GAP);
    endcase
  endfunction

  // accumulate one sample; a completed reading queues its expected result
  task automatic predict_reading(input logic [ADC_W-1:0] sample,
                                 input logic [MS_W-1:0] now);
    int              mean;
    int              temp;
    int              filt;
    logic [MS_W-1:0] elapsed;
    bit              is_low;
    bit              is_high;
    bit              fault;
    reading_t        r;
    sample_sum += int'(sample);
    sample_n++;
    if (sample_n < SPR) return;
    mean = sample_sum / SPR;
    sample_sum = 0;
    sample_n = 0;
    // signed division truncates toward zero
    temp = (int'(gain_q) * mean - int'(offset_q)) / (1 << TEMP_FRAC_W);
    // the reading that closes a block already counts in the new average
    temp_sum += temp;
    temp_n++;
    if (temp_n >= RPA) begin
      blk_avg = temp_sum / RPA;
      temp_sum = 0;
      temp_n = 0;
    end
    filt = temp + blk_avg;
    fault = 1'b0;
    is_low = mean <= int'(low_lim_q);
    is_high = mean >= int'(high_lim_q);
    if (is_low || is_high) begin
      // elapsed wraps mod 2^16, so a long fault can drop out for a while
      elapsed = now - ok_stamp;
      if (elapsed > delay_q) begin
        if (is_low && !hi_latch) begin
          lo_latch = 1'b1;
          hi_latch = 1'b0;
        end else begin
          lo_latch = 1'b0;
          hi_latch = 1'b1;
        end
        fault = 1'b1;
      end
    end else begin
      ok_stamp = now;
      lo_latch = 1'b0;
      hi_latch = 1'b0;
    end
    if (fault) filt = 0;
    r.filtered = filt[FILT_W-1:0];
    r.mean     = mean[ADC_W-1:0];
    r.fault    = fault;
    r.src_high = hi_latch;
    r.src_low  = lo_latch;
    expected_readings.push_back(r);
  endtask

  task automatic check_reading();
    reading_t want;
    if (expected_readings.size() == 0) begin
      $error("unexpected reading: filtered_half_deg %0d mean_sample %0d",
             res_if.filtered_half_deg, res_if.mean_sample);
      err_cnt++;
      return;
    end
    want = expected_readings.pop_front();
    if (res_if.filtered_half_deg !== want.filtered) begin
      $error("filtered_half_deg: expected %0d, got %0d", want.filtered,
             res_if.filtered_half_deg);
      err_cnt++;
    end
    if (res_if.mean_sample !== want.mean) begin
      $error("mean_sample: expected %0d, got %0d", want.mean, res_if.mean_sample);
      err_cnt++;
    end
    if (res_if.fault !== want.fault) begin
      $error("fault: expected %0b, got %0b", want.fault, res_if.fault);
      err_cnt++;
    end
    if (res_if.source_high !== want.src_high) begin
      $error("source_high: expected %0b, got %0b", want.src_high, res_if.source_high);
      err_cnt++;
    end
    if (res_if.source_low !== want.src_low) begin
      $error("source_low: expected %0b, got %0b", want.src_low, res_if.source_low);
      err_cnt++;
    end
  endtask

  // sample driver: predicts on each accepted request, then offers the next
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_valid && samp_if.ready) predict_reading(s_sample, s_now);
      if (!s_valid || samp_if.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          sent_req = pending_reqs.pop_front();
          s_valid  <= 1'b1;
          s_sample <= sent_req.sample;
          s_now    <= sent_req.now_ms;
          src_gap  = sent_req.gap;
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: checks each accepted request, then stalls for a drawn
  // number of cycles; a hold request blocks the output for a long stretch
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && r_ready) begin
        check_reading();
        snk_gap = draw_gap(snk_mode);
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        r_ready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap--;
        r_ready <= 1'b0;
      end else begin
        r_ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    c_valid <= 1'b1;
    c_index <= idx;
    c_data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    // fields narrower than the data bus keep only their low bits
    case (idx)
      adctf_pkg::CFG_LOW_LIMIT:   low_lim_q  = val[LIMIT_W-1:0];
      adctf_pkg::CFG_HIGH_LIMIT:  high_lim_q = val[LIMIT_W-1:0];
      adctf_pkg::CFG_FAULT_DELAY: delay_q    = val[DELAY_W-1:0];
      adctf_pkg::CFG_CONV_GAIN:   gain_q     = val[GAIN_W-1:0];
      adctf_pkg::CFG_CONV_OFFSET: offset_q   = val[OFFSET_W-1:0];
      default: ;
    endcase
    c_valid <= 1'b0;
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] low, high, delay, gain, offset);
    write_reg(adctf_pkg::CFG_LOW_LIMIT, low);
    write_reg(adctf_pkg::CFG_HIGH_LIMIT, high);
    write_reg(adctf_pkg::CFG_FAULT_DELAY, delay);
    write_reg(adctf_pkg::CFG_CONV_GAIN, gain);
    write_reg(adctf_pkg::CFG_CONV_OFFSET, offset);
  endtask

  // target mean for a reading of the given class under the current limits
  function automatic int pick_mean(input level_e lvl);
    int v;
    case (lvl)
      LVL_OK: begin
        if (int'(high_lim_q) - int'(low_lim_q) >= 2)
          return $urandom_range(int'(low_lim_q) + 1, int'(high_lim_q) - 1);
        return $urandom_range(0, ADC_MAX);
      end
      LVL_LOW:  return $urandom_range(0, int'(low_lim_q));
      LVL_HIGH: return $urandom_range(int'(high_lim_q), ADC_MAX);
      LVL_BORDER: begin
        case ($urandom_range(0, 5))
          0:       v = int'(low_lim_q);
          1:       v = int'(low_lim_q) + 1;
          2:       v = int'(high_lim_q) - 1;
          3:       v = int'(high_lim_q);
          4:       v = 0;
          default: v = ADC_MAX;
        endcase
        if (v < 0) v = 0;
        if (v > ADC_MAX) v = ADC_MAX;
        return v;
      end
      default: return ADC_MAX / 2;
    endcase
  endfunction

  // one reading's worth of samples; paired offsets keep the mean exact, and
  // only the completing sample's tick matters for the fault timer
  task automatic queue_reading(input level_e lvl);
    int              m;
    int              d;
    int              span;
    int              i;
    logic [MS_W-1:0] done_ms;
    adc_req_t        r;
    m = pick_mean(lvl);
    span = (m < ADC_MAX - m) ? m : ADC_MAX - m;
    if (span > 400) span = 400;
    d = 0;
    case ($urandom_range(0, 5))
      0, 1, 2: done_ms = tick + MS_W'($urandom_range(0, 40));
      // elapsed just below, at and just above the fault delay
      3:       done_ms = ok_guess + delay_q + MS_W'($urandom_range(0, 2)) - 1'b1;
      4:       done_ms = MS_W'($urandom);
      default: done_ms = tick + MS_W'($urandom_range(0, 2000));
    endcase
    for (i = 0; i < SPR; i++) begin
      if (i % 2 == 0) d = (i + 1 < SPR) ? int'($urandom_range(0, span)) : 0;
      if (lvl == LVL_WIDE) r.sample = ADC_W'($urandom);
      else r.sample = ADC_W'((i % 2 == 0) ? m + d : m - d);
      if (i == SPR - 1) r.now_ms = done_ms;
      else if ($urandom_range(0, 7) == 0) r.now_ms = MS_W'($urandom);
      else r.now_ms = tick + MS_W'(i);
      r.gap = draw_gap(src_mode);
      pending_reqs.push_back(r);
    end
    tick = done_ms;
    if (lvl == LVL_OK) ok_guess = done_ms;
  endtask

  // runs of same-class readings so faults get time to persist, mixed with
  // wide random noise
  task automatic queue_readings(input int count);
    level_e lvl;
    int     run;
    int     i;
    while (count > 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: lvl = LVL_OK;
        4, 5:       lvl = LVL_LOW;
        6, 7:       lvl = LVL_HIGH;
        8:          lvl = LVL_BORDER;
        default:    lvl = LVL_WIDE;
      endcase
      run = $urandom_range(1, 5);
      for (i = 0; i < run && count > 0; i++) begin
        queue_reading(lvl);
        count--;
      end
    end
  endtask

  // sender pause: all requests out, every reading back, pipeline flushed
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || s_valid || src_gap != 0 ||
           expected_readings.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    int       ph;
    int       i;
    adc_req_t r;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed reading: field extremes and alternating bit patterns; the
    // mean lands above the default high limit long after the last good tick
    for (i = 0; i < SPR; i++) begin
      case (i % 4)
        0: begin
          r.sample = '0;
          r.now_ms = '0;
        end
        1: begin
          r.sample = '1;
          r.now_ms = '1;
        end
        2: begin
          r.sample = 12'hAAA;
          r.now_ms = 16'hAAAA;
        end
        default: begin
          r.sample = 12'h555;
          r.now_ms = 16'h5555;
        end
      endcase
      r.gap = 0;
      pending_reqs.push_back(r);
    end
    wait_drained();

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        // reset values stay in place
        0: ;
        // widest window, immediate fault, full gain, no offset
        1: program_regs(CFG_DATA_W'(0), CFG_DATA_W'(ADC_MAX), CFG_DATA_W'(0),
                        CFG_DATA_W'((1 << GAIN_W) - 1), CFG_DATA_W'(0));
        // crossed limits, fault never reported, zero gain, full offset
        2: program_regs(CFG_DATA_W'(ADC_MAX), CFG_DATA_W'(0),
                        CFG_DATA_W'((1 << DELAY_W) - 1), CFG_DATA_W'(0),
                        CFG_DATA_W'((1 << OFFSET_W) - 1));
        // crossed limits with a short delay, plus a write to an unused index
        3: begin
          program_regs(CFG_DATA_W'($urandom_range(2048, ADC_MAX)),
                       CFG_DATA_W'($urandom_range(0, 2047)),
                       CFG_DATA_W'($urandom_range(0, 300)),
                       CFG_DATA_W'($urandom_range(0, (1 << GAIN_W) - 1)),
                       CFG_DATA_W'($urandom_range(0, (1 << OFFSET_W) - 1)));
          write_reg(CFG_IDX_W'($urandom_range(int'(adctf_pkg::CFG_CONV_OFFSET) + 1,
                                              (1 << CFG_IDX_W) - 1)),
                    CFG_DATA_W'($urandom));
        end
        PRESSURE_PHASE: program_regs(CFG_DATA_W'(adctf_pkg::LOW_LIMIT_RST),
                                     CFG_DATA_W'(adctf_pkg::HIGH_LIMIT_RST),
                                     CFG_DATA_W'(adctf_pkg::FAULT_DELAY_RST),
                                     CFG_DATA_W'(adctf_pkg::CONV_GAIN_RST),
                                     CFG_DATA_W'(adctf_pkg::CONV_OFFSET_RST));
        // random settings, junk in the unused upper data bits
        default: program_regs(
          CFG_DATA_W'($urandom_range(0, 1500)) | (CFG_DATA_W'($urandom) << LIMIT_W),
          CFG_DATA_W'($urandom_range(1500, ADC_MAX)) | (CFG_DATA_W'($urandom) << LIMIT_W),
          ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom)
                                      : CFG_DATA_W'($urandom_range(0, 2500)),
          CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
      endcase
      @(negedge clk_i);
      src_mode = idle_mode_e'($urandom_range(0, 2));
      snk_mode = idle_mode_e'($urandom_range(0, 2));
      if (ph == PRESSURE_PHASE) begin
        // back-to-back samples against a blocked output fill the pipeline
        src_mode = IDLE_NONE;
        hold_req = 1'b1;
        queue_readings(PRESSURE_READINGS);
      end else begin
        queue_readings(READINGS_PER_PHASE);
      end
      wait_drained();
    end

    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/adctf_pkg.sv
hdl/adctf_sample_if.sv
hdl/adctf_result_if.sv
hdl/adctf_cfg_if.sv
hdl/adc_temperature_filter_fault_monitor.sv
tb/tb_adc_temperature_filter_fault_monitor.sv
